>>> rtl/qtp_pkg.sv
// Shared constants and types for the quintic trajectory position pipeline.
package qtp_pkg;

	localparam int TIME_FRAC_BITS_DEF = 8;
	localparam int POSITION_WIDTH_DEF = 16;

	localparam int TIME_W     = 24;
	localparam int TT_W       = 16;
	localparam int U_FRAC     = 16;
	localparam int U_W        = 21;
	localparam int A_W        = 24;
	localparam int B_W        = 27;
	localparam int C_W        = 31;
	localparam int D_W        = 35;
	localparam int E_W        = 39;
	localparam int CFG_IDX_W  = 2;

	localparam logic [U_W-1:0] U_CLAMP  = U_W'(16 << U_FRAC);
	localparam logic [A_W-1:0] A_OFFSET = A_W'(15 << U_FRAC);
	localparam logic [B_W-1:0] B_OFFSET = B_W'(10 << U_FRAC);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOTAL_TIME      = 2'd0,
		REG_START_POSITION  = 2'd1,
		REG_TARGET_POSITION = 2'd2
	} cfg_reg_t;

endpackage

>>> rtl/qtp_div.sv
// Pipelined restoring divider: normalized time u = sample_time / total_time, clamped to 16.0.
module qtp_div #(
	parameter int TIME_FRAC_BITS = qtp_pkg::TIME_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [qtp_pkg::TIME_W-1:0]  sample_time,
	input  logic [qtp_pkg::TT_W-1:0]    total_time,
	output logic                        out_valid,
	output logic [qtp_pkg::U_W-1:0]     u
);
	import qtp_pkg::*;

	localparam int SHIFT = U_FRAC - TIME_FRAC_BITS;
	localparam int DIV_W = TIME_W + SHIFT;

	logic [DIV_W-1:0] dividend;
	logic [DIV_W-1:0] upper;

	logic             v_s     [0:U_W];
	logic             clamp_s [0:U_W];
	logic [TT_W-1:0]  rem_s   [0:U_W];
	logic [U_W-1:0]   qx_s    [0:U_W];

	logic             valid_s22;
	logic [U_W-1:0]   u_s22;
	logic [U_W-1:0]   quot;
	logic             over;

	assign dividend = DIV_W'(sample_time) << SHIFT;
	assign upper    = dividend >> U_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]   <= upper[TT_W-1:0];
			qx_s[0]    <= dividend[U_W-1:0];
			clamp_s[0] <= upper >= DIV_W'(total_time);
		end
	end

	for (genvar i = 0; i < U_W; i++) begin : g_step
		logic [TT_W:0]   shifted;
		logic [TT_W+1:0] trial;
		logic            qbit;

		assign shifted = {rem_s[i], qx_s[i][U_W-1]};
		assign trial   = {1'b0, shifted} - {2'b00, total_time};
		assign qbit    = ~trial[TT_W+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]   <= qbit ? trial[TT_W-1:0] : shifted[TT_W-1:0];
				qx_s[i+1]    <= {qx_s[i][U_W-2:0], qbit};
				clamp_s[i+1] <= clamp_s[i];
			end
		end
	end

	assign quot = qx_s[U_W];
	assign over = clamp_s[U_W] || (quot > U_CLAMP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s22 <= 1'b0;
		end else if (en) begin
			valid_s22 <= v_s[U_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s22 <= over ? U_CLAMP : quot;
		end
	end

	assign out_valid = valid_s22;
	assign u         = u_s22;

endmodule

>>> rtl/qtp_poly.sv
// Horner evaluation of the quintic blend s(u) = 10u^3 - 15u^4 + 6u^5 in Q16.
module qtp_poly (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [qtp_pkg::U_W-1:0]  u,
	output logic                     out_valid,
	output logic [qtp_pkg::E_W-1:0]  e
);
	import qtp_pkg::*;

	logic [A_W-1:0]            a_next;
	logic                      v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [A_W-1:0]     a_s1;
	logic [U_W-1:0]            u_s1, u_s2, u_s3, u_s4, u_s5;
	logic signed [A_W+U_W:0]   ab_s2;
	logic [B_W-1:0]            b_s3;
	logic [B_W+U_W-1:0]        bc_s4;
	logic [C_W+U_W-1:0]        cd_s5;
	logic [D_W+U_W-1:0]        de_s6;

	assign a_next = A_W'({u, 1'b0}) + A_W'({u, 2'b00}) - A_OFFSET;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= a_next;
			u_s1  <= u;
			ab_s2 <= a_s1 * $signed({1'b0, u_s1});
			u_s2  <= u_s1;
			b_s3  <= B_W'(ab_s2 >>> U_FRAC) + B_OFFSET;
			u_s3  <= u_s2;
			bc_s4 <= b_s3 * u_s3;
			u_s4  <= u_s3;
			cd_s5 <= bc_s4[U_FRAC +: C_W] * u_s4;
			u_s5  <= u_s4;
			de_s6 <= cd_s5[U_FRAC +: D_W] * u_s5;
		end
	end

	assign out_valid = v_s6;
	assign e         = de_s6[U_FRAC +: E_W];

endmodule

>>> rtl/qtp_scale.sv
// Scale the blend by the move distance, add the start, round and saturate.
module qtp_scale #(
	parameter int POSITION_WIDTH = qtp_pkg::POSITION_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic [qtp_pkg::E_W-1:0]          e,
	input  logic signed [POSITION_WIDTH:0]   delta,
	input  logic signed [POSITION_WIDTH-1:0] start,
	output logic                             out_valid,
	output logic signed [POSITION_WIDTH-1:0] position,
	output logic                             saturated
);
	import qtp_pkg::*;

	localparam int EC_W  = (POSITION_WIDTH + U_FRAC < E_W) ? POSITION_WIDTH + U_FRAC : E_W;
	localparam int EH_W  = EC_W - U_FRAC;
	localparam int PH_W  = POSITION_WIDTH + EH_W + 2;
	localparam int PL_W  = POSITION_WIDTH + U_FRAC + 2;
	localparam int SUM_W = 2 * POSITION_WIDTH + 3;

	localparam logic signed [PL_W:0]    RND     = (PL_W + 1)'(1 << (U_FRAC - 1));
	localparam logic signed [SUM_W-1:0] POS_MAX = (SUM_W'(1) << (POSITION_WIDTH - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] POS_MIN = -(SUM_W'(1) << (POSITION_WIDTH - 1));

	logic                      ebig;
	logic                      v_s1, v_s2, v_s3;
	logic                      big_s1, big_s2;
	logic signed [PH_W-1:0]    ph_s1;
	logic signed [PL_W-1:0]    pl_s1;
	logic signed [PL_W:0]      pl_rnd;
	logic signed [SUM_W-1:0]   y_s2;
	logic signed [SUM_W-1:0]   sum;
	logic signed [POSITION_WIDTH-1:0] pos_s3;
	logic                      sat_s3;

	assign ebig   = (e >> EC_W) != '0;
	assign pl_rnd = {pl_s1[PL_W-1], pl_s1} + RND;
	assign sum    = SUM_W'(start) + y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1  <= delta * $signed({1'b0, e[EC_W-1:U_FRAC]});
			pl_s1  <= delta * $signed({1'b0, e[U_FRAC-1:0]});
			big_s1 <= ebig;
			y_s2   <= SUM_W'(ph_s1) + SUM_W'(pl_rnd >>> U_FRAC);
			big_s2 <= big_s1;
			if (big_s2 && (delta != '0)) begin
				pos_s3 <= delta[POSITION_WIDTH] ? POS_MIN[POSITION_WIDTH-1:0]
				                                : POS_MAX[POSITION_WIDTH-1:0];
				sat_s3 <= 1'b1;
			end else if (sum > POS_MAX) begin
				pos_s3 <= POS_MAX[POSITION_WIDTH-1:0];
				sat_s3 <= 1'b1;
			end else if (sum < POS_MIN) begin
				pos_s3 <= POS_MIN[POSITION_WIDTH-1:0];
				sat_s3 <= 1'b1;
			end else begin
				pos_s3 <= sum[POSITION_WIDTH-1:0];
				sat_s3 <= 1'b0;
			end
		end
	end

	assign out_valid = v_s3;
	assign position  = pos_s3;
	assign saturated = sat_s3;

endmodule

>>> rtl/qtp_obuf.sv
// Output register with a skid entry, so the pipeline runs while a result waits.
module qtp_obuf #(
	parameter int W = qtp_pkg::POSITION_WIDTH_DEF + 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [W-1:0] in_data,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);
	logic         main_v_q, skid_v_q;
	logic [W-1:0] main_q, skid_q;
	logic         take;

	assign in_ready = !skid_v_q;
	assign take     = !main_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			main_v_q <= skid_v_q || in_valid;
			skid_v_q <= 1'b0;
		end else if (in_valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			main_q <= skid_v_q ? skid_q : in_data;
		end else if (in_valid && !skid_v_q) begin
			skid_q <= in_data;
		end
	end

	assign out_valid = main_v_q;
	assign out_data  = main_q;

endmodule

>>> rtl/quintic_trajectory_position.sv
// Top level: configuration registers, divider, polynomial and scaling pipeline, output buffer.
//
// channel  handshake                  payload
// -------  -------------------------  ----------------------------------
// sample   sample_valid/sample_ready  sample_time
// result   result_valid/result_ready  position, saturated
// cfg      cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One transaction per cycle in both directions when neither side stalls; a sample passes
// through 23 divider stages, six polynomial stages, three scaling stages and one output
// register before its result leaves.
// cfg_ready is always high; total_time resets to 1, both positions to 0.
// A stalled result parks in a skid entry; sample_ready drops only once that entry is full,
// and the whole pipeline then holds in place.
module quintic_trajectory_position #(
	parameter int  TIME_FRAC_BITS = qtp_pkg::TIME_FRAC_BITS_DEF,
	parameter int  POSITION_WIDTH = qtp_pkg::POSITION_WIDTH_DEF,
	localparam int CFG_W = (POSITION_WIDTH > qtp_pkg::TT_W) ? POSITION_WIDTH : qtp_pkg::TT_W
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_ready,
	input  logic [qtp_pkg::TIME_W-1:0]       sample_time,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic signed [POSITION_WIDTH-1:0] position,
	output logic                             saturated,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [qtp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]                 cfg_data
);
	import qtp_pkg::*;

	localparam logic signed [POSITION_WIDTH-1:0] OUT_MAX = {1'b0, {(POSITION_WIDTH-1){1'b1}}};
	localparam logic signed [POSITION_WIDTH-1:0] OUT_MIN = {1'b1, {(POSITION_WIDTH-1){1'b0}}};

	logic [TT_W-1:0]                  total_time_q;
	logic signed [POSITION_WIDTH-1:0] start_q, target_q;
	logic signed [POSITION_WIDTH:0]   delta_q;

	logic                      en;
	logic                      div_valid;
	logic [U_W-1:0]            div_u;
	logic                      poly_valid;
	logic [E_W-1:0]            poly_e;
	logic                      scale_valid;
	logic signed [POSITION_WIDTH-1:0] scale_pos;
	logic                      scale_sat;
	logic [POSITION_WIDTH:0]   buf_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_time_q <= TT_W'(1);
			start_q      <= '0;
			target_q     <= '0;
			delta_q      <= '0;
		end else begin
			delta_q <= (POSITION_WIDTH + 1)'(target_q) - (POSITION_WIDTH + 1)'(start_q);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TOTAL_TIME:      total_time_q <= cfg_data[TT_W-1:0];
					REG_START_POSITION:  start_q      <= cfg_data[POSITION_WIDTH-1:0];
					REG_TARGET_POSITION: target_q     <= cfg_data[POSITION_WIDTH-1:0];
					default: ;
				endcase
			end
		end
	end

	qtp_div #(
		.TIME_FRAC_BITS(TIME_FRAC_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (sample_valid),
		.sample_time(sample_time),
		.total_time (total_time_q),
		.out_valid  (div_valid),
		.u          (div_u)
	);

	qtp_poly u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (div_valid),
		.u        (div_u),
		.out_valid(poly_valid),
		.e        (poly_e)
	);

	qtp_scale #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (poly_valid),
		.e        (poly_e),
		.delta    (delta_q),
		.start    (start_q),
		.out_valid(scale_valid),
		.position (scale_pos),
		.saturated(scale_sat)
	);

	qtp_obuf #(
		.W(POSITION_WIDTH + 1)
	) u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (scale_valid),
		.in_data  ({scale_sat, scale_pos}),
		.in_ready (en),
		.out_valid(result_valid),
		.out_ready(result_ready),
		.out_data (buf_data)
	);

	assign sample_ready = en;
	assign position     = buf_data[POSITION_WIDTH-1:0];
	assign saturated    = buf_data[POSITION_WIDTH];

	a_skid_implies_output: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> result_valid)
		else $error("skid entry full while output register empty");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sample_ready) |-> $past(result_valid && !result_ready))
		else $error("pipeline stalled without a held result");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |-> position == OUT_MAX || position == OUT_MIN)
		else $error("saturated result not at a range limit");

endmodule

>>> sim/quintic_trajectory_position_test.sv
// Self-checking testbench for the quintic trajectory position pipeline.
module quintic_trajectory_position_test;
	import qtp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int    TIME_SHIFT  = U_FRAC - TIME_FRAC_BITS_DEF;
	localparam longint Q16_ONE    = 64'sd65536;
	localparam longint Q16_CLAMP  = 16 * Q16_ONE;
	localparam longint SCALE_LIMIT = (64'sd1 <<< (POSITION_WIDTH_DEF + 16)) - 1;
	localparam longint POS_MAX    = 64'sd32767;
	localparam longint POS_MIN    = -64'sd32768;
	localparam int    DIRECTED_ROWS = 25;
	localparam int    PHASES = 16;
	localparam int    ITEMS_PER_PHASE = 100;
	localparam int    PIPE_LATENCY = 40;

	typedef struct packed {
		logic signed [15:0] position;
		logic               saturated;
	} path_point_t;

	typedef struct packed {
		logic [15:0]        total_time;
		logic signed [15:0] start_pos;
		logic signed [15:0] target_pos;
		logic [23:0]        stime;
		logic               known;
		logic signed [15:0] position;
		logic               saturated;
	} directed_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_ready;
	logic [TIME_W-1:0]    sample_time = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic signed [15:0]   position;
	logic                 saturated;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	logic [15:0]        path_total_time = 16'd1;
	logic signed [15:0] path_start = '0;
	logic signed [15:0] path_target = '0;
	path_point_t        pending_points[$];
	int                 mismatches = 0;
	int                 sender_idle_pct = 0;
	int                 recv_stall_pct = 0;
	int                 hold_request = 0;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{16'd1,     16'sd0,      16'sd0,      24'h000000, 1'b1, 16'sd0,      1'b0},
		'{16'd1,     16'sd0,      16'sd0,      24'hFFFFFF, 1'b1, 16'sd0,      1'b0},
		'{16'd100,  -16'sd1000,   16'sd1000,   24'h000000, 1'b1, -16'sd1000,  1'b0},
		'{16'd100,  -16'sd1000,   16'sd1000,   24'd25600,  1'b1, 16'sd1000,   1'b0},
		'{16'd100,  -16'sd1000,   16'sd1000,   24'd12800,  1'b0, 16'sd0,      1'b0},
		'{16'd100,  -16'sd1000,   16'sd1000,   24'd6400,   1'b0, 16'sd0,      1'b0},
		'{16'd100,  -16'sd1000,   16'sd1000,   24'd51200,  1'b1, 16'sd32767,  1'b1},
		'{16'd100,  -16'sd1000,   16'sd1000,   24'hFFFFFF, 1'b1, 16'sd32767,  1'b1},
		'{16'd0,     16'sd5,     -16'sd7,      24'd123,    1'b1, -16'sd32768, 1'b1},
		'{16'd0,     16'sd300,    16'sd300,    24'hFFFFFF, 1'b1, 16'sd300,    1'b0},
		'{16'd0,     16'sd300,    16'sd300,    24'h000000, 1'b1, 16'sd300,    1'b0},
		'{16'd65535, -16'sd32768, 16'sd32767,  24'h000000, 1'b1, -16'sd32768, 1'b0},
		'{16'd65535, -16'sd32768, 16'sd32767,  24'hFFFF00, 1'b1, 16'sd32767,  1'b0},
		'{16'd65535, -16'sd32768, 16'sd32767,  24'h800000, 1'b0, 16'sd0,      1'b0},
		'{16'd65535, -16'sd32768, 16'sd32767,  24'h7FFFFF, 1'b0, 16'sd0,      1'b0},
		'{16'd65535, -16'sd32768, 16'sd32767,  24'hFFFFFF, 1'b0, 16'sd0,      1'b0},
		'{16'd1,     16'sd32767, -16'sd32768,  24'd1,      1'b0, 16'sd0,      1'b0},
		'{16'd1,     16'sd32767, -16'sd32768,  24'd255,    1'b0, 16'sd0,      1'b0},
		'{16'd1,     16'sd32767, -16'sd32768,  24'd256,    1'b1, -16'sd32768, 1'b0},
		'{16'd1,     16'sd32767, -16'sd32768,  24'd512,    1'b1, -16'sd32768, 1'b1},
		'{16'd3,     16'sd0,      16'sd1,      24'd128,    1'b0, 16'sd0,      1'b0},
		'{16'd3,     16'sd0,      16'sd1,      24'd384,    1'b0, 16'sd0,      1'b0},
		'{16'd1000,  16'sd0,      16'sd10,     24'd281600, 1'b0, 16'sd0,      1'b0},
		'{16'd7,    -16'sd32768, -16'sd32768,  24'h800000, 1'b1, -16'sd32768, 1'b0},
		'{16'd2,     16'sd1,     -16'sd1,      24'd256,    1'b0, 16'sd0,      1'b0}
	};

	quintic_trajectory_position u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_time  (sample_time),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.position     (position),
		.saturated    (saturated),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic path_point_t quintic_position(input logic [TIME_W-1:0] t);
		longint u, a, b, c, d, e, delta, mag, full;
		path_point_t point;
		point.saturated = 1'b0;
		if (path_total_time == 16'd0) begin
			u = Q16_CLAMP;
		end else begin
			u = (longint'(t) <<< TIME_SHIFT) / longint'(path_total_time);
			if (u > Q16_CLAMP) begin
				u = Q16_CLAMP;
			end
		end
		a = 6 * u - 15 * Q16_ONE;
		b = ((a * u) >>> 16) + 10 * Q16_ONE;
		c = (b * u) >>> 16;
		d = (c * u) >>> 16;
		e = (d * u) >>> 16;
		delta = longint'(path_target) - longint'(path_start);
		mag = (delta < 0) ? -delta : delta;
		if (mag != 0 && e > SCALE_LIMIT / mag) begin
			full = (delta > 0) ? POS_MAX : POS_MIN;
			point.saturated = 1'b1;
		end else begin
			full = longint'(path_start) + ((delta * e + 64'sd32768) >>> 16);
			if (full > POS_MAX) begin
				full = POS_MAX;
				point.saturated = 1'b1;
			end else if (full < POS_MIN) begin
				full = POS_MIN;
				point.saturated = 1'b1;
			end
		end
		point.position = full[15:0];
		return point;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		case (idx)
			REG_TOTAL_TIME:      path_total_time = data;
			REG_START_POSITION:  path_start = data;
			REG_TARGET_POSITION: path_target = data;
			default: ;
		endcase
	endtask

	task automatic apply_path_config(input logic [15:0] tt, input logic [15:0] p0,
			input logic [15:0] p1, input bit spare);
		write_reg(REG_TOTAL_TIME, tt);
		write_reg(REG_START_POSITION, p0);
		write_reg(REG_TARGET_POSITION, p1);
		if (spare) begin
			write_reg(REG_SPARE, 16'($urandom));
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_points();
		sample_valid <= 1'b0;
		while (pending_points.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic send_sample(input logic [TIME_W-1:0] t, input path_point_t point);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_time  <= t;
		@(posedge clk);
		while (!sample_ready) begin
			@(posedge clk);
		end
		pending_points.push_back(point);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				result_ready <= 1'b0;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		path_point_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_points.size() == 0) begin
				report_mismatch($sformatf("unexpected result position=%0d saturated=%0b",
					position, saturated));
			end else begin
				want = pending_points.pop_front();
				if (position !== want.position) begin
					report_mismatch($sformatf("position %0d, expected %0d",
						position, want.position));
				end
				if (saturated !== want.saturated) begin
					report_mismatch($sformatf("saturated %0b, expected %0b",
						saturated, want.saturated));
				end
			end
		end
	end

	initial begin
		#(20 * 400000);
		$display("simulation failed");
		$finish;
	end

	initial begin
		int row;
		int phase;
		int pick;
		int unsigned lim;
		int p0_i;
		int p1_i;
		logic [15:0] tt;
		logic [TIME_W-1:0] t;
		path_point_t point;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIRECTED_ROWS; row++) begin
			if (directed_rows[row].total_time != path_total_time ||
					directed_rows[row].start_pos != path_start ||
					directed_rows[row].target_pos != path_target) begin
				drain_points();
				apply_path_config(directed_rows[row].total_time, directed_rows[row].start_pos,
					directed_rows[row].target_pos, 1'b0);
			end
			if (directed_rows[row].known) begin
				point.position  = directed_rows[row].position;
				point.saturated = directed_rows[row].saturated;
			end else begin
				point = quintic_position(directed_rows[row].stime);
			end
			send_sample(directed_rows[row].stime, point);
		end

		for (phase = 0; phase < PHASES; phase++) begin
			drain_points();
			case (phase % 6)
				0: tt = 16'd1;
				1: tt = 16'd65535;
				2: tt = 16'($urandom_range(16, 2));
				3: tt = 16'($urandom_range(4000, 17));
				4: tt = 16'($urandom_range(65535, 1));
				default: tt = (phase == 5) ? 16'd0 : 16'($urandom_range(65535, 0));
			endcase
			case (phase % 3)
				0: begin
					p0_i = $urandom;
					p1_i = $urandom;
				end
				1: begin
					p0_i = int'($urandom_range(2000, 0)) - 1000;
					p1_i = p0_i + int'($urandom_range(200, 0)) - 100;
				end
				default: begin
					p0_i = ((phase / 3) % 2 == 0) ? 32767 : -32768;
					p1_i = -p0_i - 1;
				end
			endcase
			apply_path_config(tt, 16'(p0_i), 16'(p1_i), phase % 4 == 0);
			case (phase % 4)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct  = 0;
				end
				1: begin
					sender_idle_pct = 62;
					recv_stall_pct  = 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct  = 62;
				end
				default: begin
					sender_idle_pct = 19;
					recv_stall_pct  = 19;
				end
			endcase
			if (phase == 6) begin
				sender_idle_pct = 0;
				hold_request = 600;
			end
			lim = (tt == 16'd0) ? 32'hFFFFFF : int'(tt) * 320;
			if (lim > 32'hFFFFFF) begin
				lim = 32'hFFFFFF;
			end
			repeat (ITEMS_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					t = TIME_W'($urandom_range(lim, 0));
				end else if (pick < 85) begin
					t = TIME_W'($urandom);
				end else if (pick < 92) begin
					t = TIME_W'({tt, 8'h00}) + TIME_W'($urandom_range(2, 0)) - TIME_W'(1);
				end else begin
					t = ($urandom_range(1) == 0) ? '0 : '1;
				end
				send_sample(t, quintic_position(t));
			end
		end

		sample_valid <= 1'b0;
		drain_points();
		repeat (PIPE_LATENCY) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
